### rtl/ffa_pkg.sv
// Shared types and constants of the first-fit aligned sub-allocator.
package ffa_pkg;

    localparam logic       OP_ALLOC   = 1'b0;
    localparam logic       OP_RELEASE = 1'b1;

    localparam logic [2:0] ST_ALLOCATED = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_RELEASED  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    localparam logic CFG_TOTAL_SIZE = 1'b0;
    localparam logic CFG_BASE_ALIGN = 1'b1;

    localparam logic [31:0] RESET_TOTAL = 32'h1000_0000;
    localparam logic [4:0]  RESET_ALIGN = 5'd0;

    typedef struct packed {
        logic        opcode;
        logic [31:0] request_size;
        logic [4:0]  request_align_log2;
        logic [4:0]  release_handle;
    } ffa_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  handle;
        logic [31:0] aligned_offset;
        logic [31:0] range_offset;
        logic [31:0] range_size;
        logic [31:0] used_total;
        logic        all_free;
    } ffa_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT,
        S_LOAD,
        S_SCAN,
        S_APPLY,
        S_RESP
    } ffa_state_t;

    // Command and operand broadcast from the controller to every cell.
    typedef struct packed {
        logic        init;
        logic        start;
        logic        step;
        logic        is_rel;
        logic        shrink;
        logic        remove;
        logic        grow_prev;
        logic        prepend;
        logic        insert;
        logic [31:0] init_len;
        logic [31:0] rel_start;
        logic [31:0] rel_len;
        logic [31:0] size;
        logic [31:0] mask;
        logic [31:0] grow;
    } ffa_bus_t;

    // What a cell shows to its two neighbors.
    typedef struct packed {
        logic        occ;
        logic        passed;
        logic        tok;
        logic [31:0] start;
        logic [31:0] len;
    } ffa_nbr_t;

    // Report of the cell where the search token stopped; zero elsewhere.
    typedef struct packed {
        logic        stop;
        logic        hit;
        logic        prev_touch;
        logic        next_touch;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] al;
        logic [31:0] need;
    } ffa_rpt_t;

endpackage

### rtl/ffa_cell.sv
// One cell of the free-range chain: holds one range and talks to its neighbors.
module ffa_cell #(
    parameter bit IS_FIRST = 1'b0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ffa_pkg::ffa_bus_t bus,
    input  ffa_pkg::ffa_nbr_t left,
    input  ffa_pkg::ffa_nbr_t right,
    input  logic            tok_in,
    output ffa_pkg::ffa_nbr_t self_nbr,
    output logic            pass_out,
    output ffa_pkg::ffa_rpt_t rpt
);
    import ffa_pkg::*;

    logic [31:0] start_reg, start_next;
    logic [31:0] len_reg, len_next;
    logic        occ_reg, occ_next;
    logic        tok_reg, tok_next;
    logic        passed_reg, passed_next;

    logic [32:0] al_sum;
    logic [32:0] al_full;
    logic [33:0] need_full;
    logic        fit;
    logic        pass_cond;
    logic        stop;
    logic [32:0] left_end;
    logic [32:0] rel_end;

    always_comb
    begin
        al_sum    = {1'b0, start_reg} + {1'b0, bus.mask};
        al_full   = al_sum & ~{1'b0, bus.mask};
        need_full = {1'b0, al_full - {1'b0, start_reg}} + {2'b00, bus.size};
        fit       = (need_full <= {2'b00, len_reg});
        pass_cond = occ_reg && (bus.is_rel ? (start_reg < bus.rel_start) : !fit);
        stop      = tok_reg && !pass_cond;
        pass_out  = bus.step && tok_reg && pass_cond;
        left_end  = {1'b0, left.start} + {1'b0, left.len};
        rel_end   = {1'b0, bus.rel_start} + {1'b0, bus.rel_len};
    end

    always_comb
    begin
        rpt = '0;
        if (stop)
        begin
            rpt.stop       = 1'b1;
            rpt.hit        = occ_reg && fit;
            rpt.prev_touch = !IS_FIRST && (left_end == {1'b0, bus.rel_start});
            rpt.next_touch = occ_reg && (rel_end == {1'b0, start_reg});
            rpt.start      = start_reg;
            rpt.len        = len_reg;
            rpt.al         = al_full[31:0];
            rpt.need       = need_full[31:0];
        end
        self_nbr = '{occ: occ_reg, passed: passed_reg, tok: tok_reg,
                     start: start_reg, len: len_reg};
    end

    always_comb
    begin
        start_next  = start_reg;
        len_next    = len_reg;
        occ_next    = occ_reg;
        tok_next    = tok_reg;
        passed_next = passed_reg;
        if (bus.init)
        begin
            start_next  = '0;
            len_next    = IS_FIRST ? bus.init_len : '0;
            occ_next    = IS_FIRST && (bus.init_len != '0);
            tok_next    = 1'b0;
            passed_next = 1'b0;
        end
        else
        begin
            if (bus.start)
            begin
                tok_next    = IS_FIRST;
                passed_next = 1'b0;
            end
            if (bus.step)
            begin
                if (tok_reg && pass_cond)
                begin
                    tok_next    = 1'b0;
                    passed_next = 1'b1;
                end
                if (tok_in)
                begin
                    tok_next = 1'b1;
                end
            end
            if (bus.shrink && tok_reg)
            begin
                start_next = start_reg + need_full[31:0];
                len_next   = len_reg - need_full[31:0];
            end
            if (bus.remove && !passed_reg)
            begin
                start_next = right.start;
                len_next   = right.len;
                occ_next   = right.occ;
            end
            if (bus.grow_prev && right.tok)
            begin
                len_next = len_reg + bus.grow;
            end
            if (bus.prepend && tok_reg)
            begin
                start_next = bus.rel_start;
                len_next   = len_reg + bus.rel_len;
            end
            if (bus.insert && !passed_reg)
            begin
                if (IS_FIRST || left.passed)
                begin
                    start_next = bus.rel_start;
                    len_next   = bus.rel_len;
                    occ_next   = 1'b1;
                end
                else
                begin
                    start_next = left.start;
                    len_next   = left.len;
                    occ_next   = left.occ;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            len_reg    <= IS_FIRST ? RESET_TOTAL : '0;
            occ_reg    <= IS_FIRST;
            tok_reg    <= 1'b0;
            passed_reg <= 1'b0;
        end
        else
        begin
            start_reg  <= start_next;
            len_reg    <= len_next;
            occ_reg    <= occ_next;
            tok_reg    <= tok_next;
            passed_reg <= passed_next;
        end
    end

endmodule

### rtl/ffa_live_mem.sv
// Handle table memory holding start and length of each live allocation.
module ffa_live_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data
);
    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/first_fit_aligned_suballocator.sv
// Top level of the first-fit aligned sub-allocator with a chain of free-range cells.
//
// The free list lives in a row of FREE_ENTRIES cells, one range per cell, kept in
// ascending offset order. A request passes a search token down the row one cell
// per clock; an allocate stops at the first range that fits the aligned request,
// a release stops at the first range at or above the released offset. Shrinking,
// removing, merging and inserting then happen in the S_APPLY state, with each cell
// taking data from its left or right neighbor. An allocate first walks the handle
// table for the lowest free slot, one slot per clock. An allocate that finds a slot
// passes S_SLOT, S_SCAN, S_APPLY and S_RESP; a release of a live non-empty
// allocation passes S_LOAD, S_SCAN, S_APPLY and S_RESP. A new request transaction
// is taken while an earlier result still waits on the response side. Writing either
// configuration register reinitializes the cells, the handle table and the counters,
// but not the state machine; cfg_ready is always high.
module first_fit_aligned_suballocator #(
    parameter int FREE_ENTRIES = 64,
    parameter int LIVE_ENTRIES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ffa_pkg::ffa_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ffa_pkg::ffa_rsp_t rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data
);
    import ffa_pkg::*;

    localparam int LW = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
    localparam int SW = $clog2(LIVE_ENTRIES + 1);
    localparam int FW = $clog2(FREE_ENTRIES + 1);

    ffa_state_t state_reg, state_next;

    logic [31:0]             total_reg, total_next;
    logic [4:0]              base_reg, base_next;
    logic [4:0]              align_reg, align_next;
    logic [FW-1:0]           free_cnt_reg, free_cnt_next;
    logic [SW-1:0]           live_cnt_reg, live_cnt_next;
    logic [31:0]             used_reg, used_next;
    logic [LIVE_ENTRIES-1:0] live_valid_reg, live_valid_next;
    logic [SW-1:0]           slot_reg, slot_next;
    ffa_req_t                req_reg, req_next;
    logic [31:0]             op_s_reg, op_s_next;
    logic [31:0]             op_len_reg, op_len_next;
    logic                    tail_reg, tail_next;
    ffa_rpt_t                rpt_reg, rpt_next;
    ffa_rsp_t                res_reg, res_next;
    ffa_rsp_t                rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    ffa_bus_t                bus;
    ffa_nbr_t                nbr [FREE_ENTRIES];
    ffa_nbr_t                tail_nbr;
    logic [FREE_ENTRIES-1:0] pass_w;
    ffa_rpt_t                rpt_w [FREE_ENTRIES];
    ffa_rpt_t                rpt_all;
    ffa_rpt_t                tail_rpt;
    logic [32:0]             tail_end;

    logic          req_accept;
    logic          cfg_we;
    logic          rel_ok;
    logic [LW-1:0] rh_idx;
    logic [LW-1:0] slot_idx;
    logic [31:0]   mask;
    logic          slot_free;
    logic          out_free;

    logic          mem_we;
    logic [63:0]   mem_wdata;
    logic          mem_re;
    logic [63:0]   mem_rdata;

    // Cell row. The last cell sees a virtual right neighbor whose token is the
    // token that walked off the end of the row.
    always_comb
    begin
        tail_nbr     = '0;
        tail_nbr.tok = tail_reg;
    end

    for (genvar i = 0; i < FREE_ENTRIES; i++)
    begin : g_cell
        ffa_nbr_t left_n;
        ffa_nbr_t right_n;
        logic     tok_in;

        if (i == 0)
        begin : g_first
            assign left_n = '0;
            assign tok_in = 1'b0;
        end
        else
        begin : g_rest
            assign left_n = nbr[i-1];
            assign tok_in = pass_w[i-1];
        end

        if (i == FREE_ENTRIES - 1)
        begin : g_last
            assign right_n = tail_nbr;
        end
        else
        begin : g_mid
            assign right_n = nbr[i+1];
        end

        ffa_cell #(
            .IS_FIRST (i == 0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bus      (bus),
            .left     (left_n),
            .right    (right_n),
            .tok_in   (tok_in),
            .self_nbr (nbr[i]),
            .pass_out (pass_w[i]),
            .rpt      (rpt_w[i])
        );
    end

    ffa_live_mem #(
        .DEPTH (LIVE_ENTRIES),
        .AW    (LW)
    ) u_live_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (slot_idx),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (rh_idx),
        .rd_data (mem_rdata)
    );

    // Only the cell holding the token reports, so an OR over the row selects it.
    // A token that ran off the end reports as a stop after the last range.
    always_comb
    begin
        tail_end            = {1'b0, nbr[FREE_ENTRIES-1].start}
                            + {1'b0, nbr[FREE_ENTRIES-1].len};
        tail_rpt            = '0;
        tail_rpt.stop       = tail_reg;
        tail_rpt.prev_touch = tail_reg && (tail_end == {1'b0, op_s_reg});
        rpt_all             = tail_rpt;
        for (int i = 0; i < FREE_ENTRIES; i++)
        begin
            rpt_all = rpt_all | rpt_w[i];
        end
    end

    always_comb
    begin
        req_accept = req_valid && !req_stall;
        cfg_we     = cfg_valid && cfg_ready;
        rel_ok     = ({27'd0, req.release_handle} < 32'(LIVE_ENTRIES))
                   && live_valid_reg[LW'(req.release_handle)];
        rh_idx     = req_accept ? LW'(req.release_handle) : LW'(req_reg.release_handle);
        slot_idx   = LW'(slot_reg);
        slot_free  = !live_valid_reg[slot_idx];
        mask       = ~(32'hFFFF_FFFF << align_reg);
        out_free   = !rsp_valid_reg || !rsp_stall;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    if (req.opcode == OP_ALLOC)
                    begin
                        state_next = S_SLOT;
                    end
                    else if (rel_ok)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SLOT:
            begin
                if (slot_reg == SW'(LIVE_ENTRIES))
                begin
                    state_next = S_RESP;
                end
                else if (slot_free)
                begin
                    state_next = S_SCAN;
                end
            end
            S_LOAD:
            begin
                state_next = (mem_rdata[31:0] == '0) ? S_RESP : S_SCAN;
            end
            S_SCAN:
            begin
                if (rpt_all.stop)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, cell commands and table updates.
    always_comb
    begin
        total_next      = total_reg;
        base_next       = base_reg;
        align_next      = align_reg;
        free_cnt_next   = free_cnt_reg;
        live_cnt_next   = live_cnt_reg;
        used_next       = used_reg;
        live_valid_next = live_valid_reg;
        slot_next       = slot_reg;
        req_next        = req_reg;
        op_s_next       = op_s_reg;
        op_len_next     = op_len_reg;
        tail_next       = tail_reg;
        rpt_next        = rpt_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        mem_we          = 1'b0;
        mem_wdata       = {rpt_reg.start, rpt_reg.need};
        mem_re          = 1'b0;

        bus           = '0;
        bus.is_rel    = (req_reg.opcode == OP_RELEASE);
        bus.init_len  = total_reg;
        bus.rel_start = op_s_reg;
        bus.rel_len   = op_len_reg;
        bus.size      = req_reg.request_size;
        bus.mask      = mask;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            if (cfg_index == CFG_TOTAL_SIZE)
            begin
                total_next = cfg_data;
            end
            else
            begin
                base_next = cfg_data[4:0];
            end
            bus.init        = 1'b1;
            bus.init_len    = total_next;
            align_next      = base_next;
            free_cnt_next   = (total_next != '0) ? FW'(1) : '0;
            live_cnt_next   = '0;
            used_next       = '0;
            live_valid_next = '0;
            tail_next       = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_accept)
                    begin
                        req_next        = req;
                        res_next        = '0;
                        slot_next       = '0;
                        if (req.opcode == OP_ALLOC)
                        begin
                            if (req.request_align_log2 > align_reg)
                            begin
                                align_next = req.request_align_log2;
                            end
                        end
                        else
                        begin
                            res_next.handle = req.release_handle;
                            res_next.status = ST_UNKNOWN;
                            mem_re          = rel_ok;
                        end
                    end
                end
                S_SLOT:
                begin
                    if (slot_reg == SW'(LIVE_ENTRIES))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else if (slot_free)
                    begin
                        bus.start = 1'b1;
                        tail_next = 1'b0;
                    end
                    else
                    begin
                        slot_next = slot_reg + SW'(1);
                    end
                end
                S_LOAD:
                begin
                    op_s_next                    = mem_rdata[63:32];
                    op_len_next                  = mem_rdata[31:0];
                    live_valid_next[rh_idx]      = 1'b0;
                    live_cnt_next                = live_cnt_reg - SW'(1);
                    used_next                    = used_reg - mem_rdata[31:0];
                    res_next.status              = ST_RELEASED;
                    res_next.range_offset        = mem_rdata[63:32];
                    res_next.range_size          = mem_rdata[31:0];
                    if (mem_rdata[31:0] != '0)
                    begin
                        bus.start = 1'b1;
                        tail_next = 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (rpt_all.stop)
                    begin
                        rpt_next = rpt_all;
                    end
                    else
                    begin
                        bus.step  = 1'b1;
                        tail_next = tail_reg || pass_w[FREE_ENTRIES-1];
                    end
                end
                S_APPLY:
                begin
                    if (req_reg.opcode == OP_ALLOC)
                    begin
                        if (rpt_reg.hit)
                        begin
                            if (rpt_reg.need < rpt_reg.len)
                            begin
                                bus.shrink = 1'b1;
                            end
                            else
                            begin
                                bus.remove    = 1'b1;
                                free_cnt_next = free_cnt_reg - FW'(1);
                            end
                            mem_we                    = 1'b1;
                            live_valid_next[slot_idx] = 1'b1;
                            live_cnt_next             = live_cnt_reg + SW'(1);
                            used_next                 = used_reg + rpt_reg.need;
                            res_next.status           = ST_ALLOCATED;
                            res_next.handle           = 5'(slot_reg);
                            res_next.aligned_offset   = rpt_reg.al;
                            res_next.range_offset     = rpt_reg.start;
                            res_next.range_size       = rpt_reg.need;
                        end
                        else
                        begin
                            res_next.status = ST_NO_FIT;
                        end
                    end
                    else
                    begin
                        // Merge with the range before, the range after, both, or
                        // open a new range; a new range is dropped if the row is full.
                        priority if (rpt_reg.prev_touch && rpt_reg.next_touch)
                        begin
                            bus.grow_prev = 1'b1;
                            bus.grow      = op_len_reg + rpt_reg.len;
                            bus.remove    = 1'b1;
                            free_cnt_next = free_cnt_reg - FW'(1);
                        end
                        else if (rpt_reg.prev_touch)
                        begin
                            bus.grow_prev = 1'b1;
                            bus.grow      = op_len_reg;
                        end
                        else if (rpt_reg.next_touch)
                        begin
                            bus.prepend = 1'b1;
                        end
                        else if (free_cnt_reg < FW'(FREE_ENTRIES))
                        begin
                            bus.insert    = 1'b1;
                            free_cnt_next = free_cnt_reg + FW'(1);
                        end
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        rsp_next            = res_reg;
                        rsp_next.used_total = used_reg;
                        rsp_next.all_free   = (free_cnt_reg == FW'(1))
                                            && (live_cnt_reg == '0);
                        rsp_valid_next      = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Port outputs.
    always_comb
    begin
        req_stall = (state_reg != S_IDLE);
        cfg_ready = 1'b1;
        rsp_valid = rsp_valid_reg;
        rsp       = rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= RESET_TOTAL;
            base_reg       <= RESET_ALIGN;
            align_reg      <= RESET_ALIGN;
            free_cnt_reg   <= FW'(1);
            live_cnt_reg   <= '0;
            used_reg       <= '0;
            live_valid_reg <= '0;
            slot_reg       <= '0;
            tail_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            base_reg       <= base_next;
            align_reg      <= align_next;
            free_cnt_reg   <= free_cnt_next;
            live_cnt_reg   <= live_cnt_next;
            used_reg       <= used_next;
            live_valid_reg <= live_valid_next;
            slot_reg       <= slot_next;
            tail_reg       <= tail_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        op_s_reg   <= op_s_next;
        op_len_reg <= op_len_next;
        rpt_reg    <= rpt_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

endmodule

### bench/testbench.sv
// Self-checking testbench for the first-fit aligned sub-allocator.
//
// A behavioral allocator model predicts every response: the sorted free-range
// list, the handle table, the byte count and the sticky alignment. Each
// accepted request transaction is run through the model right away and the
// predicted response is queued. Each accepted response transaction is compared
// field by field with the oldest queued prediction.
module testbench;
    import ffa_pkg::*;

    localparam int FREE_N = 64;
    localparam int LIVE_N = 32;
    localparam int CYCLE_LIMIT = 400000;

    // Scoreboard that owns the allocator model and the queue of predicted responses.
    class alloc_scoreboard;
        logic [31:0] total_bytes;
        logic [4:0]  base_align;
        logic [63:0] rng_start [FREE_N];
        logic [63:0] rng_len [FREE_N];
        int          rng_count;
        bit          slot_live [LIVE_N];
        logic [63:0] slot_start [LIVE_N];
        logic [63:0] slot_len [LIVE_N];
        logic [31:0] bytes_used;
        logic [4:0]  align_now;
        ffa_rsp_t    pending [$];
        int          errors;

        function void restart();
            for (int i = 0; i < FREE_N; i++)
            begin
                rng_start[i] = 0;
                rng_len[i] = 0;
            end
            for (int i = 0; i < LIVE_N; i++)
            begin
                slot_live[i] = 0;
                slot_start[i] = 0;
                slot_len[i] = 0;
            end
            rng_len[0] = {32'd0, total_bytes};
            rng_count = (total_bytes != 0) ? 1 : 0;
            bytes_used = 0;
            align_now = base_align;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == CFG_TOTAL_SIZE)
                total_bytes = val;
            else
                base_align = val[4:0];
            restart();
        endfunction

        function void drop_range(int idx);
            for (int k = idx; k + 1 < rng_count; k++)
            begin
                rng_start[k] = rng_start[k + 1];
                rng_len[k] = rng_len[k + 1];
            end
            rng_count--;
        endfunction

        function void return_range(logic [63:0] st, logic [63:0] ln);
            int pos;
            bit joined;
            pos = 0;
            joined = 0;
            if (ln == 0)
                return;
            while (pos < rng_count && rng_start[pos] < st)
                pos++;
            if (pos > 0 && rng_start[pos - 1] + rng_len[pos - 1] == st)
            begin
                rng_len[pos - 1] += ln;
                joined = 1;
                if (pos < rng_count && st + ln == rng_start[pos])
                begin
                    rng_len[pos - 1] += rng_len[pos];
                    drop_range(pos);
                end
            end
            else if (pos < rng_count && st + ln == rng_start[pos])
            begin
                rng_start[pos] = st;
                rng_len[pos] += ln;
                joined = 1;
            end
            if (joined || rng_count >= FREE_N)
                return;
            for (int k = rng_count; k > pos; k--)
            begin
                rng_start[k] = rng_start[k - 1];
                rng_len[k] = rng_len[k - 1];
            end
            rng_start[pos] = st;
            rng_len[pos] = ln;
            rng_count++;
        endfunction

        // Note an accepted request and queue the response it must produce.
        function void note_request(ffa_req_t r);
            ffa_rsp_t e;
            int slot;
            bit any_live;
            logic [63:0] step, s, al, need;
            e = '0;
            if (r.opcode == OP_ALLOC)
            begin
                if (r.request_align_log2 > align_now)
                    align_now = r.request_align_log2;
                slot = LIVE_N;
                for (int i = LIVE_N - 1; i >= 0; i--)
                    if (!slot_live[i])
                        slot = i;
                if (slot >= LIVE_N)
                    e.status = ST_FULL;
                else
                begin
                    step = 64'd1 << align_now;
                    e.status = ST_NO_FIT;
                    for (int i = 0; i < rng_count; i++)
                    begin
                        s = rng_start[i];
                        al = (s + step - 1) & ~(step - 1);
                        need = (al - s) + {32'd0, r.request_size};
                        if (need <= rng_len[i])
                        begin
                            if (need < rng_len[i])
                            begin
                                rng_len[i] -= need;
                                rng_start[i] += need;
                            end
                            else
                                drop_range(i);
                            bytes_used = bytes_used + need[31:0];
                            slot_live[slot] = 1;
                            slot_start[slot] = s;
                            slot_len[slot] = need;
                            e.status = ST_ALLOCATED;
                            e.handle = slot[4:0];
                            e.aligned_offset = al[31:0];
                            e.range_offset = s[31:0];
                            e.range_size = need[31:0];
                            break;
                        end
                    end
                end
            end
            else
            begin
                if (slot_live[r.release_handle])
                begin
                    slot_live[r.release_handle] = 0;
                    e.range_offset = slot_start[r.release_handle][31:0];
                    e.range_size = slot_len[r.release_handle][31:0];
                    bytes_used = bytes_used - e.range_size;
                    return_range(slot_start[r.release_handle], slot_len[r.release_handle]);
                    e.status = ST_RELEASED;
                end
                else
                    e.status = ST_UNKNOWN;
                e.handle = r.release_handle;
            end
            any_live = 0;
            for (int i = 0; i < LIVE_N; i++)
                any_live |= slot_live[i];
            e.used_total = bytes_used;
            e.all_free = (rng_count == 1 && !any_live);
            pending = {pending, e};
        endfunction

        // Compare one accepted response with the oldest prediction.
        function void check_response(ffa_rsp_t a);
            ffa_rsp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual %p", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
                $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
            if (a.handle !== e.handle)
                $display("%0t: handle expected %0d actual %0d", $time, e.handle, a.handle);
            if (a.aligned_offset !== e.aligned_offset)
                $display("%0t: aligned_offset expected %h actual %h", $time,
                         e.aligned_offset, a.aligned_offset);
            if (a.range_offset !== e.range_offset)
                $display("%0t: range_offset expected %h actual %h", $time,
                         e.range_offset, a.range_offset);
            if (a.range_size !== e.range_size)
                $display("%0t: range_size expected %h actual %h", $time,
                         e.range_size, a.range_size);
            if (a.used_total !== e.used_total)
                $display("%0t: used_total expected %h actual %h", $time,
                         e.used_total, a.used_total);
            if (a.all_free !== e.all_free)
                $display("%0t: all_free expected %0d actual %0d", $time,
                         e.all_free, a.all_free);
            if (a !== e)
                errors++;
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    ffa_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    ffa_rsp_t rsp;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_index;
    logic [31:0] cfg_data;

    alloc_scoreboard board;
    int  cycles;
    int  gap_pct;       // Percent of cycles on which the request side idles.
    bit  hold_rsp;      // Set while the receiver holds off for a long stretch.
    int  rsp_pct;

    first_fit_aligned_suballocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
    end

    always #2 clk = ~clk;

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver side: random stalls, or a solid stall while hold_rsp is set.
    // Responses are sampled at the same edge at which they are accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp);
            rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_pct);
        end
    end

    // Offer one request transaction and hold it until accepted. Idle cycles are
    // inserted before the transaction at the requested rate; valid stays high
    // after acceptance until the next transaction, an idle cycle or a drain
    // replaces it in the same time step.
    task automatic send_request(ffa_req_t r);
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(r);
    endtask

    task automatic alloc_item(logic [31:0] sz, logic [4:0] al);
        ffa_req_t r;
        r = '0;
        r.opcode = OP_ALLOC;
        r.request_size = sz;
        r.request_align_log2 = al;
        r.release_handle = 5'($urandom);
        send_request(r);
    endtask

    task automatic release_item(logic [4:0] h);
        ffa_req_t r;
        r = '0;
        r.opcode = OP_RELEASE;
        r.request_size = $urandom;
        r.request_align_log2 = 5'($urandom);
        r.release_handle = h;
        send_request(r);
    endtask

    // Wait until every predicted response has come, then let the block settle.
    task automatic drain();
        req_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // A random item shaped to stay mostly successful: sizes are small next to
    // the managed block, and releases mostly target handles that may be live.
    task automatic random_item(int scale);
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            alloc_item($urandom_range(scale), $urandom_range(99) < 85 ?
                       5'($urandom_range(6)) : 5'($urandom_range(31)));
        else if (pick < 55)
            alloc_item($urandom, 5'($urandom));
        else
            release_item(5'($urandom_range(31)));
    endtask

    initial
    begin
        board = new();
        board.total_bytes = RESET_TOTAL;
        board.base_align = RESET_ALIGN;
        board.errors = 0;
        board.restart();
        cycles = 0;
        gap_pct = 18;
        rsp_pct = 18;
        hold_rsp = 0;
        rst_n = 0;
        req_valid = 0;
        req = '0;
        rsp_stall = 0;
        cfg_valid = 0;
        cfg_index = CFG_TOTAL_SIZE;
        cfg_data = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings: zero-byte request, an exact fit,
        // alignment raised by failing requests, unknown handles, and merging.
        alloc_item(32'd0, 5'd0);
        alloc_item(32'd100, 5'd0);
        alloc_item(32'd16, 5'd4);
        alloc_item(32'hFFFF_FFFF, 5'd31);
        alloc_item(32'd8, 5'd0);
        release_item(5'd1);
        release_item(5'd1);
        release_item(5'd31);
        release_item(5'd0);
        release_item(5'd2);
        release_item(5'd3);
        alloc_item(32'h1000_0000, 5'd0);
        release_item(5'd0);
        drain();

        // Tiny block: exact fits, table full, and free-list fragmentation.
        write_reg(CFG_TOTAL_SIZE, 32'd64);
        write_reg(CFG_BASE_ALIGN, 32'd0);
        for (int i = 0; i < 33; i++)
            alloc_item(32'd2, 5'd0);
        alloc_item(32'd0, 5'd0);
        for (int i = 0; i < 32; i += 2)
            release_item(i[4:0]);
        alloc_item(32'd64, 5'd0);
        drain();

        // Zero-sized block and the largest block with the highest base alignment.
        write_reg(CFG_TOTAL_SIZE, 32'd0);
        alloc_item(32'd0, 5'd0);
        release_item(5'd0);
        drain();
        write_reg(CFG_TOTAL_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_BASE_ALIGN, 32'd31);
        alloc_item(32'h8000_0000, 5'd0);
        alloc_item(32'h7FFF_FFFF, 5'd0);
        alloc_item(32'h7FFF_FFFF, 5'd0);
        drain();

        // Random phases over several settings; the middle phase has no idling
        // and also holds off the receiver at its start, so that the request side stalls.
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(CFG_TOTAL_SIZE, ph == 0 ? 32'd4096 : ph == 1 ? 32'hFFFF_FFFF :
                      ph == 4 ? 32'd1 : $urandom_range(65536, 1));
            write_reg(CFG_BASE_ALIGN, ph == 3 ? 32'd3 : 32'd0);
            if (ph == 2)
            begin
                gap_pct = 0;
                rsp_pct = 0;
                hold_rsp = 1;
                fork
                    begin
                        repeat (600) @(posedge clk);
                        hold_rsp = 0;
                    end
                join_none
            end
            for (int n = 0; n < 75; n++)
                random_item(ph == 1 ? 32'h0FFF_FFFF : ph == 4 ? 2 : 300);
            // Pause the sender until every prediction has been met.
            drain();
            gap_pct = 18;
            rsp_pct = 18;
        end

        drain();
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
